/* sv/u8tok_pkg.sv */
// ----------------------------------------------------------------------------
// u8tok_pkg
// Shared types, constants and character functions of the UTF-8 word tokeniser.
// ----------------------------------------------------------------------------
package u8tok_pkg;

    localparam int MAX_RES     = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RES);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SURR_LO    = 21'h00D800;
    localparam logic [20:0] SURR_HI    = 21'h00DFFF;
    localparam logic [20:0] MIN_CLS1   = 21'h000080;
    localparam logic [20:0] MIN_CLS2   = 21'h000800;
    localparam logic [20:0] MIN_CLS3   = 21'h010000;
    localparam logic [20:0] HYPHEN_U1  = 21'h002010;
    localparam logic [20:0] HYPHEN_U2  = 21'h002011;
    localparam logic [7:0]  HYPHEN_A   = 8'h2D;
    localparam logic [7:0]  END_BYTE   = 8'h00;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_TWO  = 2'd1;
    localparam logic [1:0] CLS_THREE = 2'd2;
    localparam logic [1:0] CLS_FOUR = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0]   res;
        logic [RES_IDX_W-1:0] last_idx;
    } t_bundle;

    function automatic logic is_token(input logic [20:0] cp);
        logic r;
        r = (cp inside {[21'h30:21'h39], [21'h41:21'h5A], [21'h61:21'h7A],
                        [21'h400:21'h481], [21'h48A:21'h4FF]});
        return r;
    endfunction

    function automatic logic is_dash(input logic [20:0] cp);
        logic r;
        r = (cp == {13'd0, HYPHEN_A}) || (cp == HYPHEN_U1) || (cp == HYPHEN_U2);
        return r;
    endfunction

    // token codepoints all sit below 0x500
    function automatic logic [10:0] lower_cp(input logic [10:0] cp);
        logic        even;
        logic [10:0] r;
        even = ~cp[0];
        r    = cp;
        if (cp inside {[11'h41:11'h5A], [11'h410:11'h42F]}) begin
            r = cp + 11'h20;
        end else if (cp inside {[11'h400:11'h40F]}) begin
            r = cp + 11'h50;
        end else if (even && (cp inside {[11'h460:11'h481], [11'h48A:11'h4BF],
                                         [11'h4D0:11'h4F9]})) begin
            r = cp + 11'h1;
        end else if (!even && (cp inside {[11'h4C1:11'h4CE]})) begin
            r = cp + 11'h1;
        end else if (cp == 11'h4C0) begin
            r = 11'h4CF;
        end
        return r;
    endfunction

endpackage

/* sv/utf8_word_tokenizer_lowercase.sv */
// ----------------------------------------------------------------------------
// utf8_word_tokenizer_lowercase
// Strict UTF-8 decoder and word tokeniser with Latin/Cyrillic lowercasing.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata = in_byte, s_tlast = text_end
//  m_       out        m_tvalid/m_tready  m_tdata = token_byte,
//                                         m_tuser = token_end, m_tlast = last_of_run
//  cfg      in         i_cfg_valid/o_cfg_ready  i_cfg_data = keep_inner_hyphen
//
//  One input byte per cycle while s_tready is high; the decoder resolves each
//  byte in the cycle of its transfer, and a byte yields up to four results.
//  Queued results leave the output register one per cycle while m_tready is high.
//  s_tready drops only while the bundle queue (QueueDepth bundles) is full.
//  Reset is synchronous, active low; keep_inner_hyphen resets to 1.
// ----------------------------------------------------------------------------
module utf8_word_tokenizer_lowercase #(
    parameter int QueueDepth = u8tok_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] token_byte
    output logic       m_tuser,    // [0] token_end
    output logic       m_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic               take;
    logic               push;
    logic               full;
    logic               q_valid;
    logic               pop;
    u8tok_pkg::t_bundle f_bundle;
    u8tok_pkg::t_bundle q_bundle;

    assign s_tready    = !full;
    assign take        = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;

    u8tok_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (s_tdata),
        .i_text_end (s_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_bundle   (f_bundle)
    );

    u8tok_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (f_bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    u8tok_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_bundle   (q_bundle),
        .o_pop      (pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

/* sv/u8tok_front.sv */
// ----------------------------------------------------------------------------
// u8tok_front
// Strict UTF-8 decoder and token classifier: one byte per transfer, giving a
// bundle of up to four results per byte.
// ----------------------------------------------------------------------------
module u8tok_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic                 i_text_end,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    output logic                 o_push,
    output u8tok_pkg::t_bundle   o_bundle
);

    logic        r_keep;
    logic [1:0]  r_rem;
    logic [1:0]  r_cls;
    logic [20:0] r_acc;
    logic        r_tok_open;
    logic        r_hyp;

    logic [1:0]  n_rem;
    logic [1:0]  n_cls;
    logic [20:0] n_acc;
    logic        n_tok_open;
    logic        n_hyp;
    logic [2:0]  n_cnt;
    u8tok_pkg::t_res [u8tok_pkg::MAX_RES-1:0] n_res;

    always_comb begin
        logic        brk;
        logic        cp_ok;
        logic        cp_bad;
        logic [20:0] cp;
        logic [20:0] acc_sh;
        logic [20:0] minv;
        logic        tok;
        logic [10:0] lc;
        brk    = 1'b0;
        cp_ok  = 1'b0;
        cp_bad = 1'b0;
        cp     = '0;
        n_rem  = r_rem;
        n_cls  = r_cls;
        n_acc  = r_acc;
        acc_sh = {r_acc[14:0], i_byte[5:0]};
        case (r_cls)
            u8tok_pkg::CLS_TWO:   minv = u8tok_pkg::MIN_CLS1;
            u8tok_pkg::CLS_THREE: minv = u8tok_pkg::MIN_CLS2;
            default:              minv = u8tok_pkg::MIN_CLS3;
        endcase

        if (r_rem != 2'd0 && i_byte[7:6] == 2'b10) begin
            n_rem = r_rem - 2'd1;
            n_acc = acc_sh;
            if (n_rem == 2'd0) begin
                cp = acc_sh;
                if (acc_sh >= minv && acc_sh <= u8tok_pkg::CP_MAX &&
                    !(acc_sh >= u8tok_pkg::SURR_LO && acc_sh <= u8tok_pkg::SURR_HI)) begin
                    cp_ok = 1'b1;
                end else begin
                    cp_bad = 1'b1;
                end
                n_cls = u8tok_pkg::CLS_NONE;
                n_acc = '0;
            end
        end else begin
            brk   = (r_rem != 2'd0);
            n_rem = 2'd0;
            n_cls = u8tok_pkg::CLS_NONE;
            n_acc = '0;
            if (!i_byte[7]) begin
                cp_ok = 1'b1;
                cp    = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_rem = 2'd1;
                n_cls = u8tok_pkg::CLS_TWO;
                n_acc = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_rem = 2'd2;
                n_cls = u8tok_pkg::CLS_THREE;
                n_acc = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_rem = 2'd3;
                n_cls = u8tok_pkg::CLS_FOUR;
                n_acc = {18'd0, i_byte[2:0]};
            end else begin
                cp_bad = 1'b1;
            end
        end

        tok        = u8tok_pkg::is_token(cp);
        lc         = u8tok_pkg::lower_cp(cp[10:0]);
        n_tok_open = r_tok_open;
        n_hyp      = r_hyp;
        n_cnt      = 3'd0;
        n_res      = '0;

        // broken sequence closes the token before the byte is reread as a lead
        if (brk) begin
            n_hyp = 1'b0;
            if (n_tok_open) begin
                n_res[n_cnt[1:0]] = '{data: u8tok_pkg::END_BYTE, is_end: 1'b1};
                n_cnt = n_cnt + 3'd1;
                n_tok_open = 1'b0;
            end
        end

        if (cp_bad) begin
            n_hyp = 1'b0;
            if (n_tok_open) begin
                n_res[n_cnt[1:0]] = '{data: u8tok_pkg::END_BYTE, is_end: 1'b1};
                n_cnt = n_cnt + 3'd1;
                n_tok_open = 1'b0;
            end
        end else if (cp_ok) begin
            if (n_hyp) begin
                n_hyp = 1'b0;
                if (tok) begin
                    n_res[n_cnt[1:0]] = '{data: u8tok_pkg::HYPHEN_A, is_end: 1'b0};
                    n_cnt = n_cnt + 3'd1;
                end else if (n_tok_open) begin
                    n_res[n_cnt[1:0]] = '{data: u8tok_pkg::END_BYTE, is_end: 1'b1};
                    n_cnt = n_cnt + 3'd1;
                    n_tok_open = 1'b0;
                end
            end
            if (u8tok_pkg::is_dash(cp) && r_keep) begin
                if (n_tok_open) begin
                    n_hyp = 1'b1;
                end
            end else if (!tok) begin
                n_hyp = 1'b0;
                if (n_tok_open) begin
                    n_res[n_cnt[1:0]] = '{data: u8tok_pkg::END_BYTE, is_end: 1'b1};
                    n_cnt = n_cnt + 3'd1;
                    n_tok_open = 1'b0;
                end
            end else begin
                if (lc < 11'h80) begin
                    n_res[n_cnt[1:0]] = '{data: lc[7:0], is_end: 1'b0};
                    n_cnt = n_cnt + 3'd1;
                end else begin
                    n_res[n_cnt[1:0]] = '{data: {3'b110, lc[10:6]}, is_end: 1'b0};
                    n_cnt = n_cnt + 3'd1;
                    n_res[n_cnt[1:0]] = '{data: {2'b10, lc[5:0]}, is_end: 1'b0};
                    n_cnt = n_cnt + 3'd1;
                end
                n_tok_open = 1'b1;
            end
        end

        // end of text: truncated sequence and open token both just close
        if (i_text_end) begin
            n_hyp = 1'b0;
            if (n_tok_open) begin
                n_res[n_cnt[1:0]] = '{data: u8tok_pkg::END_BYTE, is_end: 1'b1};
                n_cnt = n_cnt + 3'd1;
                n_tok_open = 1'b0;
            end
            n_rem = 2'd0;
            n_cls = u8tok_pkg::CLS_NONE;
            n_acc = '0;
        end
    end

    assign o_push            = i_take && (n_cnt != 3'd0);
    assign o_bundle.res      = n_res;
    assign o_bundle.last_idx = u8tok_pkg::RES_IDX_W'(n_cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep     <= 1'b1;
            r_rem      <= 2'd0;
            r_cls      <= u8tok_pkg::CLS_NONE;
            r_acc      <= '0;
            r_tok_open <= 1'b0;
            r_hyp      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_data;
            end
            if (i_take) begin
                r_rem      <= n_rem;
                r_cls      <= n_cls;
                r_acc      <= n_acc;
                r_tok_open <= n_tok_open;
                r_hyp      <= n_hyp;
            end
        end
    end

endmodule

/* sv/u8tok_queue.sv */
// ----------------------------------------------------------------------------
// u8tok_queue
// Short queue of result bundles between the decoder and the serialiser.
// ----------------------------------------------------------------------------
module u8tok_queue #(
    parameter int Depth = u8tok_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8tok_pkg::t_bundle   i_bundle,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output u8tok_pkg::t_bundle   o_bundle
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    u8tok_pkg::t_bundle r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full   = (r_count == CntW'(Depth));
    assign o_valid  = (r_count != '0);
    assign o_bundle = r_mem[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/u8tok_back.sv */
// ----------------------------------------------------------------------------
// u8tok_back
// Serialiser: walks the head bundle one result per transfer into the output
// register.
// ----------------------------------------------------------------------------
module u8tok_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  u8tok_pkg::t_bundle   i_bundle,
    output logic                 o_pop,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    logic [u8tok_pkg::RES_IDX_W-1:0] r_idx;
    logic                            r_valid;
    logic [7:0]                      r_data;
    logic                            r_end;
    logic                            r_last;

    logic load;
    logic at_last;

    assign load    = i_valid && (!r_valid || i_m_tready);
    assign at_last = (r_idx == i_bundle.last_idx);
    assign o_pop   = load && at_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_bundle.res[r_idx].data;
            r_end  <= i_bundle.res[r_idx].is_end;
            r_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_end;
    assign o_m_tlast  = r_last;

endmodule

/* sv/u8tok_checker.sv */
// ----------------------------------------------------------------------------
// u8tok_checker
// Port-level checks of the tokeniser, bound to the top level.
// ----------------------------------------------------------------------------
module u8tok_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> s_tready)
        else $error("input not ready after reset");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == 8'h00)
        else $error("token end carries a byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind utf8_word_tokenizer_lowercase u8tok_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
